[rtl/pixel_invert_gray_emboss_filter_assert.svh]
// Assertion macros used by the pixel filter checker.
`ifndef PIXEL_INVERT_GRAY_EMBOSS_FILTER_ASSERT_SVH
`define PIXEL_INVERT_GRAY_EMBOSS_FILTER_ASSERT_SVH

// Check that a condition implies a consequence on the next edge, outside reset.
`define PIGEF_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error("pixel filter check failed");

// Same check, also sampled while reset is asserted.
`define PIGEF_ASSERT_NEXT_ALWAYS(label, cond, cons) \
    label: assert property (@(posedge i_clk) (cond) |=> (cons)) \
        else $error("pixel filter check failed during reset");

`endif

[rtl/pigef_pkg.sv]
// Shared types and constants of the pixel filter.
package pigef_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int CH_W          = 8;
    localparam int PIX_W         = 3 * CH_W;
    localparam int COORD_W       = 10;
    localparam int MODE_W        = 2;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 8;

    // filter mode codes
    localparam logic [MODE_W-1:0] MODE_INVERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GRAY   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EMBOSS = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_LEVEL  = 1'd1;

    localparam logic [MODE_W-1:0] FILTER_MODE_RST = MODE_INVERT;
    localparam logic [CH_W-1:0]   PEAK_LEVEL_RST  = 8'd255;

    // emboss bias and saturation level
    localparam logic [CH_W-1:0] EMBOSS_MID = 8'd128;
    localparam logic [CH_W-1:0] CH_MAX     = 8'd255;

    // divide by three for sums below 768: (s * 683) >> 11
    localparam logic [10:0] GRAY_RECIP = 11'd683;
    localparam int          GRAY_SHIFT = 11;

    typedef struct packed {
        logic [CH_W-1:0]    in_red;
        logic [CH_W-1:0]    in_green;
        logic [CH_W-1:0]    in_blue;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
    } t_pix_out;

endpackage

[rtl/pigef_in_if.sv]
// Input pixel channel: valid, ready and the pixel with its position.
interface pigef_in_if;
    logic              valid;
    logic              ready;
    pigef_pkg::t_pix_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/pigef_out_if.sv]
// Output pixel channel: valid, ready and the filtered pixel.
interface pigef_out_if;
    logic               valid;
    logic               ready;
    pigef_pkg::t_pix_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/pigef_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module pigef_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word when both ports hit the same entry
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/pigef_filter.sv]
// Per-pixel datapath: invert, grayscale and upper-left emboss.
module pigef_filter (
    input  pigef_pkg::t_pix_in                i_pix,
    input  logic [pigef_pkg::PIX_W-1:0]       i_upper_left,
    input  logic [pigef_pkg::MODE_W-1:0]      i_mode,
    input  logic [pigef_pkg::CH_W-1:0]        i_peak_level,
    output pigef_pkg::t_pix_out               o_pix
);

    function automatic logic [pigef_pkg::CH_W-1:0] level_gap(
        input logic [pigef_pkg::CH_W-1:0] a,
        input logic [pigef_pkg::CH_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [pigef_pkg::CH_W-1:0] mag(input logic signed [8:0] d);
        logic signed [8:0] m;
        m = d[8] ? -d : d;
        return m[7:0];
    endfunction

    logic [9:0]        w_sum;
    logic [20:0]       w_prod;
    logic [7:0]        w_gray;
    logic signed [8:0] w_dr;
    logic signed [8:0] w_dg;
    logic signed [8:0] w_db;
    logic signed [8:0] w_best;
    logic signed [9:0] w_biased;
    logic [7:0]        w_emboss;

    // grayscale: channel sum times reciprocal of three
    assign w_sum  = 10'(i_pix.in_red) + 10'(i_pix.in_green) + 10'(i_pix.in_blue);
    assign w_prod = 21'(w_sum) * 21'(pigef_pkg::GRAY_RECIP);
    assign w_gray = w_prod[pigef_pkg::GRAY_SHIFT +: pigef_pkg::CH_W];

    // emboss: signed differences against the upper-left pixel
    assign w_dr = $signed({1'b0, i_pix.in_red})   - $signed({1'b0, i_upper_left[23:16]});
    assign w_dg = $signed({1'b0, i_pix.in_green}) - $signed({1'b0, i_upper_left[15:8]});
    assign w_db = $signed({1'b0, i_pix.in_blue})  - $signed({1'b0, i_upper_left[7:0]});

    // pick the largest magnitude, red wins ties, then green
    always_comb begin
        w_best = w_dr;
        if (mag(w_dg) > mag(w_best)) begin
            w_best = w_dg;
        end
        if (mag(w_db) > mag(w_best)) begin
            w_best = w_db;
        end
    end

    assign w_biased = 10'(w_best) + $signed({2'b00, pigef_pkg::EMBOSS_MID});

    // clamp to the channel range; border pixels give the midpoint
    always_comb begin
        if (i_pix.column == '0 || i_pix.row == '0) begin
            w_emboss = pigef_pkg::EMBOSS_MID;
        end else if (w_biased < 0) begin
            w_emboss = '0;
        end else if (w_biased > $signed({2'b00, pigef_pkg::CH_MAX})) begin
            w_emboss = pigef_pkg::CH_MAX;
        end else begin
            w_emboss = w_biased[7:0];
        end
    end

    // select the mode; the undefined code gives black
    always_comb begin
        case (i_mode)
            pigef_pkg::MODE_INVERT: begin
                o_pix.out_red   = level_gap(i_pix.in_red, i_peak_level);
                o_pix.out_green = level_gap(i_pix.in_green, i_peak_level);
                o_pix.out_blue  = level_gap(i_pix.in_blue, i_peak_level);
            end
            pigef_pkg::MODE_GRAY: begin
                o_pix.out_red   = w_gray;
                o_pix.out_green = w_gray;
                o_pix.out_blue  = w_gray;
            end
            pigef_pkg::MODE_EMBOSS: begin
                o_pix.out_red   = w_emboss;
                o_pix.out_green = w_emboss;
                o_pix.out_blue  = w_emboss;
            end
            default: begin
                o_pix = '0;
            end
        endcase
    end

endmodule

[rtl/pigef_out_buf.sv]
// Output register with a skid entry so the input side keeps moving.
module pigef_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pigef_pkg::t_pix_out i_data,
    output logic                o_can_push,
    pigef_out_if.source         o_pix
);

    logic                r_out_valid;
    logic                n_out_valid;
    pigef_pkg::t_pix_out r_out_data;
    pigef_pkg::t_pix_out n_out_data;
    logic                r_skid_valid;
    logic                n_skid_valid;
    pigef_pkg::t_pix_out r_skid_data;
    pigef_pkg::t_pix_out n_skid_data;
    logic                w_out_free;

    assign w_out_free = !r_out_valid || o_pix.ready;
    assign o_can_push = !r_skid_valid;

    // advance the skid entry first, else load or park the new request
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (w_out_free) begin
            if (r_skid_valid) begin
                n_out_data   = r_skid_data;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (i_push) begin
                n_out_data  = i_data;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (i_push) begin
            n_skid_data  = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_pix.valid = r_out_valid;
    assign o_pix.data  = r_out_data;

endmodule

[rtl/pixel_invert_gray_emboss_filter.sv]
// Top level of the pixel filter: line store, datapath and output buffer.
//
// Pixels enter on i_pix (valid/ready) in raster order with their column and
// row; one filtered pixel per request leaves on o_pix (valid/ready).
// filter_mode (index 0) picks invert, grayscale or emboss; the peak level
// (index 1) is the level invert subtracts from. Write them through i_cfg_*
// only while no request is in flight.
// Latency: the result is valid in the cycle after the request is accepted,
// unless a stalled result still holds the output register.
// Throughput: one pixel per cycle while i_pix.ready is high, set by the line store,
// which is read and written at the pixel's column in the same cycle; the word read
// out is the upper-left neighbor of the next pixel.
// Reset clears the mode to invert, the peak level to 255 and the upper-left
// pixel to zero; the line store keeps whatever it holds. The user must write
// each entry before the next row reads it; the block itself does not enforce it.
// When the receiver stalls, the result holds in the output register and one
// more request lands in a skid entry; i_pix.ready drops only while that
// skid entry is full.
module pixel_invert_gray_emboss_filter #(
    parameter int MAX_WIDTH = pigef_pkg::MAX_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pigef_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pigef_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    pigef_in_if.sink                          i_pix,
    pigef_out_if.source                       o_pix
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);

    logic [pigef_pkg::MODE_W-1:0] r_mode;
    logic [pigef_pkg::CH_W-1:0]   r_peak_level;
    logic                         r_ul_zero;
    logic                         w_accept;
    logic                         w_in_range;
    logic                         w_store_acc;
    logic [ADDR_W-1:0]            w_addr;
    logic [pigef_pkg::PIX_W-1:0]  w_wdata;
    logic [pigef_pkg::PIX_W-1:0]  w_rdata;
    logic [pigef_pkg::PIX_W-1:0]  w_upper_left;
    logic                         w_can_push;
    pigef_pkg::t_pix_out          w_result;

    assign i_pix.ready = w_can_push;
    assign w_accept    = i_pix.valid && w_can_push;
    assign w_in_range  = 32'(i_pix.data.column) < MAX_WIDTH;
    assign w_store_acc = w_accept && w_in_range;
    assign w_addr      = ADDR_W'(i_pix.data.column);
    assign w_wdata     = {i_pix.data.in_red, i_pix.data.in_green, i_pix.data.in_blue};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= pigef_pkg::FILTER_MODE_RST;
            r_peak_level <= pigef_pkg::PEAK_LEVEL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pigef_pkg::CFG_FILTER_MODE: r_mode <= i_cfg_data[pigef_pkg::MODE_W-1:0];
                pigef_pkg::CFG_PEAK_LEVEL:  r_peak_level <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero the upper-left pixel after reset or an off-store column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ul_zero <= 1'b1;
        end else if (w_accept) begin
            r_ul_zero <= !w_in_range;
        end
    end

    // previous row, read and overwritten at the pixel's column
    pigef_ram #(
        .WIDTH (pigef_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (w_store_acc),
        .i_waddr (w_addr),
        .i_wdata (w_wdata),
        .i_re    (w_store_acc),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    assign w_upper_left = r_ul_zero ? '0 : w_rdata;

    pigef_filter u_filter (
        .i_pix        (i_pix.data),
        .i_upper_left (w_upper_left),
        .i_mode       (r_mode),
        .i_peak_level (r_peak_level),
        .o_pix        (w_result)
    );

    pigef_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_accept),
        .i_data     (w_result),
        .o_can_push (w_can_push),
        .o_pix      (o_pix)
    );

endmodule

[rtl/pigef_checker.sv]
// Port-level checks of the pixel filter and their bind to the top level.
`include "pixel_invert_gray_emboss_filter_assert.svh"

module pigef_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [pigef_pkg::PIX_W-1:0] i_out_data
);

    logic w_in_acc;

    assign w_in_acc = i_in_valid && i_in_ready;

    // a stalled result holds its value
    `PIGEF_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))
    // nothing shows on the output just after reset
    `PIGEF_ASSERT_NEXT_ALWAYS(a_rst_empty, !i_rst_n, !i_out_valid)
    // a request into an empty output shows in the next cycle
    `PIGEF_ASSERT_NEXT(a_latency, w_in_acc && !i_out_valid, i_out_valid)
    // no result appears without a request
    `PIGEF_ASSERT_NEXT(a_no_invent, !w_in_acc && !i_out_valid, !i_out_valid)

endmodule

bind pixel_invert_gray_emboss_filter pigef_checker u_pigef_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_data  (o_pix.data)
);

[sim/testbench.sv]
// Self-checking testbench of the pixel filter: directed table, random raster frames, stalls.
`timescale 1ns / 100ps

module testbench;

    localparam int CH_W        = pigef_pkg::CH_W;
    localparam int PIX_W       = pigef_pkg::PIX_W;
    localparam int COORD_W     = pigef_pkg::COORD_W;
    localparam int MODE_W      = pigef_pkg::MODE_W;
    localparam int CFG_IDX_W   = pigef_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = pigef_pkg::CFG_DATA_W;
    localparam int LINE_DEPTH  = pigef_pkg::MAX_WIDTH_DEF;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 125;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 200;
    localparam int STALL_LIMIT = 2000;
    localparam int PRINT_LIMIT = 40;

    // mode code outside the defined set; the block answers with black
    localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;

    typedef struct {
        logic [MODE_W-1:0]   mode;
        logic [CH_W-1:0]     maxv;
        pigef_pkg::t_pix_in  pix;
        bit                  typed;
        pigef_pkg::t_pix_out want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pigef_in_if  pix_in ();
    pigef_out_if pix_out ();

    pixel_invert_gray_emboss_filter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_in),
        .o_pix      (pix_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the filter: settings, previous row and upper-left pixel
    logic [MODE_W-1:0] cur_mode = pigef_pkg::FILTER_MODE_RST;
    logic [CH_W-1:0]   cur_max  = pigef_pkg::PEAK_LEVEL_RST;
    logic [PIX_W-1:0]  line_copy [LINE_DEPTH];
    bit                line_valid [LINE_DEPTH];
    logic [PIX_W-1:0]  corner_px    = '0;
    bit                corner_known = 1'b1;

    pigef_pkg::t_pix_out pending_q [$];
    int err_count     = 0;
    int sent_count    = 0;
    int checked_count = 0;
    int setting_count = 0;
    int stall_cycles  = 0;
    bit tx_busy = 1'b1;
    bit rx_busy = 1'b1;

    logic [MODE_W-1:0] mode_cycle [3] = '{pigef_pkg::MODE_INVERT, pigef_pkg::MODE_GRAY,
                                          pigef_pkg::MODE_EMBOSS};

    // Directed requests; typed rows carry their result, the rest go to the shadow model
    t_dir_row dir_table [23] = '{
        '{pigef_pkg::MODE_INVERT, 8'd255, '{8'h00, 8'h00, 8'h00, 10'd0, 10'd0}, 1'b1,
          '{8'hff, 8'hff, 8'hff}},
        '{pigef_pkg::MODE_INVERT, 8'd255, '{8'hff, 8'hff, 8'hff, 10'd1, 10'd0}, 1'b1,
          '{8'h00, 8'h00, 8'h00}},
        '{pigef_pkg::MODE_INVERT, 8'd255, '{8'h55, 8'haa, 8'h0f, 10'd2, 10'd0}, 1'b1,
          '{8'haa, 8'h55, 8'hf0}},
        '{pigef_pkg::MODE_INVERT, 8'd100, '{8'hc8, 8'h64, 8'h00, 10'd3, 10'd0}, 1'b1,
          '{8'h64, 8'h00, 8'h64}},
        '{pigef_pkg::MODE_INVERT, 8'd0,   '{8'h12, 8'h34, 8'h56, 10'd4, 10'd0}, 1'b1,
          '{8'h12, 8'h34, 8'h56}},
        '{pigef_pkg::MODE_INVERT, 8'd1,   '{8'h01, 8'h00, 8'hff, 10'd5, 10'd0}, 1'b1,
          '{8'h00, 8'h01, 8'hfe}},
        '{pigef_pkg::MODE_GRAY,   8'd1,   '{8'hff, 8'hff, 8'hff, 10'd6, 10'd0}, 1'b1,
          '{8'hff, 8'hff, 8'hff}},
        '{pigef_pkg::MODE_GRAY,   8'd1,   '{8'h00, 8'h00, 8'h00, 10'd7, 10'd0}, 1'b1,
          '{8'h00, 8'h00, 8'h00}},
        '{pigef_pkg::MODE_GRAY,   8'd1,   '{8'hff, 8'hff, 8'hfe, 10'd8, 10'd0}, 1'b1,
          '{8'hfe, 8'hfe, 8'hfe}},
        '{pigef_pkg::MODE_GRAY,   8'd1,   '{8'h02, 8'h01, 8'h00, 10'd9, 10'd0}, 1'b1,
          '{8'h01, 8'h01, 8'h01}},
        '{MODE_UNDEF,             8'd1,   '{8'hab, 8'hcd, 8'hef, 10'd10, 10'd0}, 1'b1,
          '{8'h00, 8'h00, 8'h00}},
        '{pigef_pkg::MODE_EMBOSS, 8'd1,   '{8'h09, 8'h09, 8'h09, 10'd11, 10'd0}, 1'b1,
          '{8'h80, 8'h80, 8'h80}},
        '{pigef_pkg::MODE_EMBOSS, 8'd1,   '{8'hc8, 8'h00, 8'h00, 10'd0, 10'd1}, 1'b1,
          '{8'h80, 8'h80, 8'h80}},
        '{pigef_pkg::MODE_EMBOSS, 8'd1,   '{8'hff, 8'h00, 8'h00, 10'd1, 10'd1}, 1'b1,
          '{8'hff, 8'hff, 8'hff}},
        '{pigef_pkg::MODE_EMBOSS, 8'd1,   '{8'h00, 8'h00, 8'h00, 10'd2, 10'd1}, 1'b1,
          '{8'h00, 8'h00, 8'h00}},
        '{pigef_pkg::MODE_EMBOSS, 8'd1,   '{8'h5f, 8'h96, 8'h14, 10'd3, 10'd1}, 1'b0, '0},
        '{pigef_pkg::MODE_EMBOSS, 8'd1,   '{8'hd2, 8'h5a, 8'h00, 10'd4, 10'd1}, 1'b0, '0},
        '{pigef_pkg::MODE_EMBOSS, 8'd1,   '{8'h12, 8'h34, 8'h56, 10'd5, 10'd1}, 1'b0, '0},
        '{pigef_pkg::MODE_EMBOSS, 8'd1,   '{8'h01, 8'h00, 8'h00, 10'd6, 10'd1}, 1'b0, '0},
        '{pigef_pkg::MODE_EMBOSS, 8'd1,   '{8'h80, 8'h80, 8'h80, 10'd1023, 10'd1023},
          1'b0, '0},
        '{pigef_pkg::MODE_EMBOSS, 8'd1,   '{8'h00, 8'h00, 8'h00, 10'd0, 10'd1023}, 1'b1,
          '{8'h80, 8'h80, 8'h80}},
        '{pigef_pkg::MODE_EMBOSS, 8'd1,   '{8'hff, 8'hff, 8'hff, 10'd512, 10'd3}, 1'b0, '0},
        '{pigef_pkg::MODE_INVERT, 8'd255, '{8'h00, 8'hff, 8'h00, 10'd1023, 10'd0}, 1'b1,
          '{8'hff, 8'h00, 8'hff}}
    };

    function automatic int magnitude(input int d);
        return (d < 0) ? -d : d;
    endfunction

    function automatic logic [CH_W-1:0] channel_gap(input logic [CH_W-1:0] ch,
                                                    input logic [CH_W-1:0] lvl);
        return (ch > lvl) ? ch - lvl : lvl - ch;
    endfunction

    // Largest signed channel step from the upper-left pixel, biased and clamped
    function automatic logic [CH_W-1:0] emboss_level(input pigef_pkg::t_pix_in p,
                                                     input logic [PIX_W-1:0] ul);
        int dr, dg, db, best, lvl;
        dr = int'(p.in_red)   - int'(ul[3*CH_W-1:2*CH_W]);
        dg = int'(p.in_green) - int'(ul[2*CH_W-1:CH_W]);
        db = int'(p.in_blue)  - int'(ul[CH_W-1:0]);
        best = dr;
        if (magnitude(dg) > magnitude(best)) best = dg;
        if (magnitude(db) > magnitude(best)) best = db;
        lvl = best + int'(pigef_pkg::EMBOSS_MID);
        if (lvl < 0) lvl = 0;
        if (lvl > int'(pigef_pkg::CH_MAX)) lvl = int'(pigef_pkg::CH_MAX);
        return lvl[CH_W-1:0];
    endfunction

    // Filter one pixel, then advance the line copy and the upper-left pixel
    function automatic pigef_pkg::t_pix_out advance_filter(input pigef_pkg::t_pix_in p);
        pigef_pkg::t_pix_out res;
        logic [CH_W-1:0] lvl;
        res = '0;
        case (cur_mode)
            pigef_pkg::MODE_INVERT: begin
                res.out_red   = channel_gap(p.in_red, cur_max);
                res.out_green = channel_gap(p.in_green, cur_max);
                res.out_blue  = channel_gap(p.in_blue, cur_max);
            end
            pigef_pkg::MODE_GRAY: begin
                lvl = CH_W'((int'(p.in_red) + int'(p.in_green) + int'(p.in_blue)) / 3);
                res = '{lvl, lvl, lvl};
            end
            pigef_pkg::MODE_EMBOSS: begin
                if (p.column == 0 || p.row == 0) lvl = pigef_pkg::EMBOSS_MID;
                else lvl = emboss_level(p, corner_px);
                res = '{lvl, lvl, lvl};
            end
            default: res = '0;
        endcase
        if (p.column < LINE_DEPTH) begin
            corner_px    = line_copy[p.column];
            corner_known = line_valid[p.column];
            line_copy[p.column]  = {p.in_red, p.in_green, p.in_blue};
            line_valid[p.column] = 1'b1;
        end else begin
            corner_px    = '0;
            corner_known = 1'b1;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [PIX_W-1:0] want,
                                   input logic [PIX_W-1:0] got);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("ERROR: %s at result %0d: expected %h, got %h",
                     what, checked_count, want, got);
    endtask

    task automatic check_pixel(input pigef_pkg::t_pix_out got);
        pigef_pkg::t_pix_out want;
        checked_count++;
        if (pending_q.size() == 0) begin
            report_mismatch("pixel with none pending", '0, got);
        end else begin
            want = pending_q.pop_front();
            if (got.out_red !== want.out_red)
                report_mismatch("out_red", PIX_W'(want.out_red), PIX_W'(got.out_red));
            if (got.out_green !== want.out_green)
                report_mismatch("out_green", PIX_W'(want.out_green), PIX_W'(got.out_green));
            if (got.out_blue !== want.out_blue)
                report_mismatch("out_blue", PIX_W'(want.out_blue), PIX_W'(got.out_blue));
        end
    endtask

    // Offer one request after a random gap; hold valid until it is taken
    task automatic send_pixel(input pigef_pkg::t_pix_in p, input bit typed,
                              input pigef_pkg::t_pix_out want);
        int gap;
        pigef_pkg::t_pix_out calc;
        if (sent_count % 40 == 0) tx_busy = ($urandom_range(0, 3) != 0);
        gap = tx_busy ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.data  <= p;
        do @(posedge i_clk); while (!pix_in.ready);
        calc = advance_filter(p);
        pending_q.push_back(typed ? want : calc);
        sent_count++;
    endtask

    // Keep emboss off an upper-left pixel that came from an unwritten line entry
    task automatic send_generated(input pigef_pkg::t_pix_in p);
        if (cur_mode == pigef_pkg::MODE_EMBOSS && p.column != 0 && p.row != 0
            && !corner_known)
            p.row = '0;
        send_pixel(p, 1'b0, '0);
    endtask

    // Drop valid and wait until every pending pixel has come back
    task automatic drain_pipe();
        pix_in.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_filter(input logic [MODE_W-1:0] mode, input logic [CH_W-1:0] maxv);
        drain_pipe();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= pigef_pkg::CFG_FILTER_MODE;
        i_cfg_data <= CFG_DATA_W'(mode);
        @(posedge i_clk);
        i_cfg_idx  <= pigef_pkg::CFG_PEAK_LEVEL;
        i_cfg_data <= maxv;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_mode = mode;
        cur_max  = maxv;
        setting_count++;
    endtask

    // Result side: random ready gaps, one long hold-off to back up the block
    initial begin : result_sink
        int gap;
        pix_out.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (checked_count % 50 == 0) rx_busy = ($urandom_range(0, 3) != 0);
            if (checked_count == HOLD_AT) gap = HOLD_CYCLES;
            else gap = rx_busy ? $urandom_range(0, 16) : 0;
            if (gap > 0) begin
                pix_out.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pix_out.ready <= 1'b1;
            do @(posedge i_clk); while (!pix_out.valid);
            check_pixel(pix_out.data);
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
            $display("pixel_invert_gray_emboss_filter test failed");
            $finish;
        end
    end

    initial begin : stimulus
        int ph, left, width, height, top, n;
        logic [MODE_W-1:0] mode;
        logic [CH_W-1:0]   maxv;
        pigef_pkg::t_pix_in p;

        // Hold reset with every input quiet
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= pigef_pkg::CFG_FILTER_MODE;
        i_cfg_data   <= '0;
        pix_in.valid <= 1'b0;
        pix_in.data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table, rewriting the settings where a row changes them
        for (int i = 0; i < $size(dir_table); i++) begin
            if (dir_table[i].mode != cur_mode || dir_table[i].maxv != cur_max)
                set_filter(dir_table[i].mode, dir_table[i].maxv);
            send_pixel(dir_table[i].pix, dir_table[i].typed, dir_table[i].want);
        end

        // Random phases: mostly raster frames, some scattered pixels
        for (ph = 0; ph < PHASES; ph++) begin
            mode = (ph == PHASES - 1) ? mode_cycle[$urandom_range(0, 2)] : mode_cycle[ph % 3];
            if (ph == 0) maxv = pigef_pkg::CH_MAX;
            else if (ph == 1) maxv = 8'd1;
            else maxv = CH_W'($urandom_range(1, 255));
            set_filter(mode, maxv);
            left = PHASE_ITEMS;
            while (left > 0) begin
                if ($urandom_range(0, 4) != 0) begin
                    width  = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 64)
                                                         : $urandom_range(2, 24);
                    height = $urandom_range(1, 5);
                    top    = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 1023 - height);
                    for (int y = 0; y < height && left > 0; y++) begin
                        for (int x = 0; x < width && left > 0; x++) begin
                            p.in_red   = CH_W'($urandom);
                            p.in_green = CH_W'($urandom);
                            p.in_blue  = CH_W'($urandom);
                            p.column   = COORD_W'(x);
                            p.row      = COORD_W'(top + y);
                            send_generated(p);
                            left--;
                        end
                    end
                end else begin
                    n = $urandom_range(1, 4);
                    for (int k = 0; k < n && left > 0; k++) begin
                        p.in_red   = CH_W'($urandom);
                        p.in_green = CH_W'($urandom);
                        p.in_blue  = CH_W'($urandom);
                        p.column   = COORD_W'($urandom_range(0, 1023));
                        p.row      = COORD_W'($urandom_range(0, 1023));
                        send_generated(p);
                        left--;
                    end
                end
            end
        end

        drain_pipe();
        repeat (4) @(posedge i_clk);
        $display("Ran %0d pixels over %0d filter settings: invert, grayscale, emboss, bad mode",
                 sent_count, setting_count);
        $display("Checked %0d filtered pixels, %0d field mismatches", checked_count, err_count);
        if (err_count == 0)
            $display("pixel_invert_gray_emboss_filter test passed");
        else
            $display("pixel_invert_gray_emboss_filter test failed");
        $finish;
    end

endmodule
